FILE: src/evd_pkg.sv
// evd_pkg: shared constants and the command and status bundles of the
// euclidean vector distance block; used by evd_ctrl, evd_datapath and the top level
package evd_pkg;

	// fixed widths of the result fields
	localparam int DIST_W = 24;
	localparam int SUM_W  = 48;

	localparam logic [DIST_W-1:0] DIST_MAX = {DIST_W{1'b1}};
	localparam logic [SUM_W-1:0]  SUM_MAX  = {SUM_W{1'b1}};

	// controller to datapath
	typedef struct packed {
		logic take_in;     // element word accepted this cycle
		logic root_start;  // capture the sum, clear the accumulator
		logic root_step;   // one digit of the square root
		logic load_out;    // move the result into the output register
	} cmd_t;

	// datapath to controller
	typedef struct packed {
		logic last_in_acc; // last element being added this cycle
		logic out_free;    // output register empty or being taken
	} status_t;

endpackage

FILE: src/evd_ctrl.sv
// evd_ctrl: sequencer of the euclidean vector distance block
// depends on evd_pkg for cmd_t and status_t
module evd_ctrl #(
	parameter int ROOT_BITS = 24
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	input  logic             last_elem,
	input  evd_pkg::status_t st,
	output logic             in_ready,
	output evd_pkg::cmd_t    cmd
);

	localparam int CW = $clog2(ROOT_BITS);

	localparam logic [2:0] ST_RUN   = 3'd0;
	localparam logic [2:0] ST_DRAIN = 3'd1;
	localparam logic [2:0] ST_START = 3'd2;
	localparam logic [2:0] ST_ROOT  = 3'd3;
	localparam logic [2:0] ST_HOLD  = 3'd4;

	logic [2:0]    state_q;
	logic [CW-1:0] cnt_q;

	assign in_ready = (state_q == ST_RUN);

	always_comb begin
		cmd.take_in    = in_valid && in_ready;
		cmd.root_start = (state_q == ST_START);
		cmd.root_step  = (state_q == ST_ROOT);
		cmd.load_out   = (state_q == ST_HOLD) && st.out_free;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_RUN;
			cnt_q   <= '0;
		end else begin
			unique case (state_q)
				ST_RUN: begin
					if (cmd.take_in && last_elem) state_q <= ST_DRAIN;
				end
				ST_DRAIN: begin
					if (st.last_in_acc) state_q <= ST_START;
				end
				ST_START: begin
					cnt_q   <= CW'(ROOT_BITS - 1);
					state_q <= ST_ROOT;
				end
				ST_ROOT: begin
					if (cnt_q == '0) state_q <= ST_HOLD;
					else cnt_q <= cnt_q - 1'b1;
				end
				ST_HOLD: begin
					if (st.out_free) state_q <= ST_RUN;
				end
				default: state_q <= ST_RUN;
			endcase
		end
	end

endmodule

FILE: src/evd_datapath.sv
// evd_datapath: difference, square, saturating accumulate, digit-by-digit
// square root and output register; depends on evd_pkg
module evd_datapath #(
	parameter int ELEM_BITS = 16,
	parameter int ACC_BITS  = 48
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  evd_pkg::cmd_t                 cmd,
	input  logic [ELEM_BITS-1:0]          query_elem,
	input  logic [ELEM_BITS-1:0]          base_elem,
	input  logic                          last_elem,
	input  logic                          out_ready,
	output evd_pkg::status_t              st,
	output logic                          out_valid,
	output logic [evd_pkg::DIST_W-1:0]    distance,
	output logic [evd_pkg::SUM_W-1:0]     squared_sum
);

	localparam int E       = ELEM_BITS;
	localparam int SQ_BITS = 2 * ELEM_BITS;
	localparam int AW      = ((ACC_BITS > SQ_BITS) ? ACC_BITS : SQ_BITS) + 1;
	localparam int R       = (ACC_BITS + 1) / 2;
	localparam int RW      = (R > evd_pkg::DIST_W) ? R : evd_pkg::DIST_W;
	localparam int SW      = (ACC_BITS > evd_pkg::SUM_W) ? ACC_BITS : evd_pkg::SUM_W;
	localparam logic [ACC_BITS-1:0] ACC_MAX = {ACC_BITS{1'b1}};

	// stage 1: magnitude of the difference
	logic [E:0]          diff_c;
	logic [E:0]          neg_c;
	logic [E-1:0]        absd_c;
	logic [E-1:0]        absd_s1;
	logic                last_s1;
	logic                vld_s1;

	always_comb begin
		diff_c = {query_elem[E-1], query_elem} - {base_elem[E-1], base_elem};
		neg_c  = (E+1)'(0) - diff_c;
		absd_c = diff_c[E] ? neg_c[E-1:0] : diff_c[E-1:0];
	end

	// stage 2: square
	logic [SQ_BITS-1:0]  sq_c;
	logic [SQ_BITS-1:0]  sq_s2;
	logic                last_s2;
	logic                vld_s2;

	assign sq_c = {{E{1'b0}}, absd_s1} * {{E{1'b0}}, absd_s1};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
		end else begin
			vld_s1 <= cmd.take_in;
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.take_in) begin
			absd_s1 <= absd_c;
			last_s1 <= last_elem;
		end
		if (vld_s1) begin
			sq_s2   <= sq_c;
			last_s2 <= last_s1;
		end
	end

	// saturating accumulator
	logic [AW-1:0]       total_c;
	logic [ACC_BITS-1:0] acc_nxt;
	logic [ACC_BITS-1:0] acc_q;

	always_comb begin
		total_c = AW'(acc_q) + AW'(sq_s2);
		acc_nxt = (total_c > AW'(ACC_MAX)) ? ACC_MAX : total_c[ACC_BITS-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q <= '0;
		end else if (cmd.root_start) begin
			acc_q <= '0;
		end else if (vld_s2) begin
			acc_q <= acc_nxt;
		end
	end

	// square root, one result bit per step
	logic [2*R-1:0]      rad_q;
	logic [R+1:0]        rem_q;
	logic [R-1:0]        root_q;
	logic [R+1:0]        rem_sh;
	logic [R+1:0]        trial;
	logic [SW-1:0]       sum_ext;
	logic [evd_pkg::SUM_W-1:0] sum_sat;
	logic [evd_pkg::SUM_W-1:0] sum_q;

	always_comb begin
		rem_sh  = {rem_q[R-1:0], rad_q[2*R-1 -: 2]};
		trial   = {root_q, 2'b01};
		sum_ext = SW'(acc_q);
		sum_sat = (sum_ext > SW'(evd_pkg::SUM_MAX)) ? evd_pkg::SUM_MAX
			: sum_ext[evd_pkg::SUM_W-1:0];
	end

	always_ff @(posedge clk) begin
		if (cmd.root_start) begin
			rad_q  <= (2*R)'(acc_q);
			rem_q  <= '0;
			root_q <= '0;
			sum_q  <= sum_sat;
		end else if (cmd.root_step) begin
			rad_q <= rad_q << 2;
			if (rem_sh >= trial) begin
				rem_q  <= rem_sh - trial;
				root_q <= {root_q[R-2:0], 1'b1};
			end else begin
				rem_q  <= rem_sh;
				root_q <= {root_q[R-2:0], 1'b0};
			end
		end
	end

	// output register
	logic [RW-1:0]                root_ext;
	logic [evd_pkg::DIST_W-1:0]   dist_sat;
	logic                         out_valid_q;
	logic [evd_pkg::DIST_W-1:0]   distance_q;
	logic [evd_pkg::SUM_W-1:0]    squared_sum_q;

	always_comb begin
		root_ext = RW'(root_q);
		dist_sat = (root_ext > RW'(evd_pkg::DIST_MAX)) ? evd_pkg::DIST_MAX
			: root_ext[evd_pkg::DIST_W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.load_out) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_out) begin
			distance_q    <= dist_sat;
			squared_sum_q <= sum_q;
		end
	end

	assign out_valid       = out_valid_q;
	assign distance        = distance_q;
	assign squared_sum     = squared_sum_q;
	assign st.last_in_acc  = vld_s2 && last_s2;
	assign st.out_free     = !out_valid_q || out_ready;

`ifndef ASSERT_OFF
	a_no_take_after_last: assert property (@(posedge clk) disable iff (!arst_n)
		(vld_s1 && last_s1) |-> !cmd.take_in)
		else $error("element word taken behind a last element");
	a_acc_cleared: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.root_start |=> (acc_q == '0))
		else $error("accumulator not cleared after sum capture");
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load_out |-> (!out_valid_q || out_ready))
		else $error("result overwrites a waiting result");
	a_root_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.root_step || cmd.root_start) |-> (!vld_s1 && !vld_s2 && !cmd.take_in))
		else $error("element traffic during square root");
`endif

endmodule

FILE: src/euclidean_vector_distance.sv
// euclidean_vector_distance: top level, streaming L2 distance of two vectors
// depends on evd_pkg, evd_ctrl and evd_datapath
//
// Element words (query_elem, base_elem, last_elem) are taken one per cycle
// while a vector is streaming in: the difference, its square and the
// saturating 48-bit sum run as a three-stage pipeline. Once the word marked
// last is taken, in_ready drops: the pipeline drains, the sum is captured and
// the accumulator cleared, then the square root is worked out one result bit
// per cycle (ceil(ACC_BITS/2) result bits, 24 at the default width), and the
// result moves into the output register once that register is free.
// The finished result waits in its own output register, so the next vector
// may stream in while distance and squared_sum are still waiting to be
// taken. The sum sticks at its maximum on overflow; squared_sum and distance
// saturate at their field widths when ACC_BITS is wider than 48.
module euclidean_vector_distance #(
	parameter int ELEM_BITS = 16,
	parameter int ACC_BITS  = 48
) (
	input  logic                       clk,
	input  logic                       arst_n,
	// element words in
	input  logic                       in_valid,
	output logic                       in_ready,
	input  logic [ELEM_BITS-1:0]       query_elem,
	input  logic [ELEM_BITS-1:0]       base_elem,
	input  logic                       last_elem,
	// result words out
	output logic                       out_valid,
	input  logic                       out_ready,
	output logic [evd_pkg::DIST_W-1:0] distance,
	output logic [evd_pkg::SUM_W-1:0]  squared_sum
);

	// number of result bits of the square root
	localparam int ROOT_BITS = (ACC_BITS + 1) / 2;

	evd_pkg::cmd_t    cmd;
	evd_pkg::status_t st;

	// sequencer: intake, drain, root steps, hand-off to the output register
	evd_ctrl #(
		.ROOT_BITS (ROOT_BITS)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.last_elem (last_elem),
		.st        (st),
		.in_ready  (in_ready),
		.cmd       (cmd)
	);

	// arithmetic and the output register
	evd_datapath #(
		.ELEM_BITS (ELEM_BITS),
		.ACC_BITS  (ACC_BITS)
	) u_datapath (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.query_elem  (query_elem),
		.base_elem   (base_elem),
		.last_elem   (last_elem),
		.out_ready   (out_ready),
		.st          (st),
		.out_valid   (out_valid),
		.distance    (distance),
		.squared_sum (squared_sum)
	);

endmodule

FILE: test/tb_euclidean_vector_distance.sv
// tb_euclidean_vector_distance: self-checking bench for the streaming l2 distance block
// depends on evd_pkg and euclidean_vector_distance; element words are queued up front,
// a clocked driver and monitor move them, a local model predicts each distance word
`timescale 1ns / 1ps

module tb_euclidean_vector_distance;

	localparam int ELEM_W       = 16;
	localparam int LONG_WORDS   = 64;     // one long full-scale vector
	localparam int RAND_WORDS   = 1270;
	localparam int HOLD_AT      = 20;     // result after which the receiver holds off
	localparam int HOLD_CYCLES  = 400;
	localparam int TAIL_CYCLES  = 64;     // drain, capture, 24 root steps, load, margin
	localparam int STALL_LIMIT  = 4000;

	typedef struct {
		logic [ELEM_W-1:0] q;
		logic [ELEM_W-1:0] b;
		logic              lst;
		int unsigned       gap;
	} elem_word_t;

	typedef struct {
		logic [evd_pkg::DIST_W-1:0] l2;
		logic [evd_pkg::SUM_W-1:0]  sum;
	} l2_result_t;

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              in_valid = 1'b0;
	logic              in_ready;
	logic [ELEM_W-1:0] query_elem = '0;
	logic [ELEM_W-1:0] base_elem = '0;
	logic              last_elem = 1'b0;
	logic              out_valid;
	logic              out_ready = 1'b0;
	logic [evd_pkg::DIST_W-1:0] distance;
	logic [evd_pkg::SUM_W-1:0]  squared_sum;

	// words waiting to go out, and distances waiting to come back
	elem_word_t  elem_q[$];
	l2_result_t  distance_q[$];

	// model state: the running sum of squared differences
	logic [evd_pkg::SUM_W-1:0] l2_acc = '0;

	// driver state
	elem_word_t  cur;
	bit          have_cur = 1'b0;
	int unsigned tx_idle = 0;

	// monitor state
	int unsigned rx_idle = 0;
	int unsigned results_seen = 0;
	int unsigned mismatches = 0;

	int unsigned stall_cycles = 0;

	euclidean_vector_distance u_dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.query_elem  (query_elem),
		.base_elem   (base_elem),
		.last_elem   (last_elem),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.distance    (distance),
		.squared_sum (squared_sum)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// floor of the square root, settled one root bit at a time from the top
	function automatic logic [evd_pkg::DIST_W-1:0] floor_root(logic [evd_pkg::SUM_W-1:0] n);
		logic [evd_pkg::DIST_W-1:0] root;
		logic [evd_pkg::DIST_W-1:0] cand;
		logic [evd_pkg::SUM_W-1:0]  cand_sq;
		root = '0;
		for (int i = evd_pkg::DIST_W - 1; i >= 0; i--) begin
			cand    = root | (evd_pkg::DIST_W'(1) << i);
			cand_sq = evd_pkg::SUM_W'(cand) * evd_pkg::SUM_W'(cand);
			if (cand_sq <= n)
				root = cand;
		end
		return root;
	endfunction

	// add one squared difference to the sum; on the last word queue the distance
	function automatic void fold_word(logic [ELEM_W-1:0] q, logic [ELEM_W-1:0] b, logic lst);
		logic signed [ELEM_W:0]    diff;
		logic [ELEM_W:0]           mag;
		logic [evd_pkg::SUM_W-1:0] sq;
		logic [evd_pkg::SUM_W:0]   total;
		l2_result_t                res;
		diff  = $signed({q[ELEM_W-1], q}) - $signed({b[ELEM_W-1], b});
		mag   = diff[ELEM_W] ? (ELEM_W+1)'(-diff) : (ELEM_W+1)'(diff);
		sq    = evd_pkg::SUM_W'(mag) * evd_pkg::SUM_W'(mag);
		total = {1'b0, l2_acc} + {1'b0, sq};
		// the sum sticks at full scale once it overflows
		l2_acc = total[evd_pkg::SUM_W] ? evd_pkg::SUM_MAX : total[evd_pkg::SUM_W-1:0];
		if (lst) begin
			res.sum = l2_acc;
			res.l2  = floor_root(l2_acc);
			distance_q.push_back(res);
			l2_acc = '0;
		end
	endfunction

	function automatic void queue_word(logic [ELEM_W-1:0] q, logic [ELEM_W-1:0] b, logic lst,
			int unsigned gap);
		elem_word_t w;
		w.q   = q;
		w.b   = b;
		w.lst = lst;
		w.gap = gap;
		elem_q.push_back(w);
	endfunction

	// element values: half full range, the rest small values, the rails and values next to the rails
	function automatic logic [ELEM_W-1:0] pick_elem();
		logic [ELEM_W-1:0] v;
		case ($urandom_range(0, 7))
			0, 1, 2, 3: v = ELEM_W'($urandom);
			4:          v = ELEM_W'($urandom_range(0, 16)) - ELEM_W'(8);
			5:          v = $urandom_range(0, 1) ? 16'h7fff : 16'h8000;
			default:    v = ELEM_W'($urandom_range(0, 3)) + 16'h7ffe;
		endcase
		return v;
	endfunction

	// driver: presents queued words, honouring each word's drawn idle count
	always @(posedge clk or negedge arst_n) begin
		logic nxt_valid;
		if (!arst_n) begin
			in_valid   <= 1'b0;
			query_elem <= '0;
			base_elem  <= '0;
			last_elem  <= 1'b0;
			have_cur = 1'b0;
			tx_idle  = 0;
		end else begin
			if (in_valid && in_ready)
				fold_word(query_elem, base_elem, last_elem);
			// a word still waiting for ready keeps valid and payload as they are
			if (!in_valid || in_ready) begin
				nxt_valid = 1'b0;
				if (!have_cur && elem_q.size() != 0) begin
					cur      = elem_q.pop_front();
					have_cur = 1'b1;
					tx_idle  = cur.gap;
				end
				if (have_cur) begin
					if (tx_idle != 0) begin
						tx_idle--;
					end else begin
						nxt_valid = 1'b1;
						have_cur  = 1'b0;
						query_elem <= cur.q;
						base_elem  <= cur.b;
						last_elem  <= cur.lst;
					end
				end
				in_valid <= nxt_valid;
			end
		end
	end

	// monitor: takes result words with random back-pressure and checks them in order
	always @(posedge clk or negedge arst_n) begin
		l2_result_t want;
		logic       nxt_ready;
		if (!arst_n) begin
			out_ready <= 1'b0;
			rx_idle = 0;
		end else begin
			nxt_ready = out_ready;
			if (out_valid && out_ready) begin
				if (distance_q.size() == 0) begin
					mismatches++;
					$display("%0t: result word with no vector pending: distance %0d sum %0d",
						$time, distance, squared_sum);
				end else begin
					want = distance_q.pop_front();
					if (distance !== want.l2) begin
						mismatches++;
						$display("%0t: distance expected %0d actual %0d",
							$time, want.l2, distance);
					end
					if (squared_sum !== want.sum) begin
						mismatches++;
						$display("%0t: squared_sum expected %0d actual %0d",
							$time, want.sum, squared_sum);
					end
				end
				results_seen++;
				// every fourth run of 32 results goes without any back-pressure
				if ((results_seen / 32) % 4 == 3)
					rx_idle = 0;
				else
					rx_idle = $urandom_range(0, 11);
				// one long hold so the output register and the root stage back up
				if (results_seen == HOLD_AT)
					rx_idle = HOLD_CYCLES;
				nxt_ready = (rx_idle == 0);
			end else if (!out_ready) begin
				if (rx_idle != 0)
					rx_idle--;
				nxt_ready = (rx_idle == 0);
			end
			out_ready <= nxt_ready;
		end
	end

	// watchdog on cycles in which neither channel moves a word
	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && in_ready) || (out_valid && out_ready))
				stall_cycles = 0;
			else
				stall_cycles++;
			if (stall_cycles >= STALL_LIMIT) begin
				$display("%0t: no word moved for %0d cycles", $time, STALL_LIMIT);
				$display("SCOREBOARD MISMATCH");
				$finish;
			end
		end
	end

	initial begin
		int unsigned n_words;
		int unsigned vec_len;
		bit          quiet;

		// single-word vectors: full-scale difference both ways, zero at zero and at both rails, and an alternating-bit pair
		queue_word(16'h7fff, 16'h8000, 1'b1, 0);
		queue_word(16'h8000, 16'h7fff, 1'b1, 3);
		queue_word(16'h0000, 16'h0000, 1'b1, 0);
		queue_word(16'h8000, 16'h8000, 1'b1, 1);
		queue_word(16'h7fff, 16'h7fff, 1'b1, 0);
		queue_word(16'h5555, 16'haaaa, 1'b1, 2);
		// short vectors: sums 11 and 29 round the root down, sum 16 is a perfect square
		queue_word(16'h0001, 16'h0000, 1'b0, 0);
		queue_word(16'hffff, 16'h0000, 1'b0, 5);
		queue_word(16'h0005, 16'h0002, 1'b1, 0);
		queue_word(16'h0004, 16'h0000, 1'b0, 0);
		queue_word(16'h0000, 16'h0000, 1'b1, 0);
		queue_word(16'hffff, 16'h0001, 1'b0, 11);
		queue_word(16'h0003, 16'h0000, 1'b0, 0);
		queue_word(16'h0000, 16'h0004, 1'b1, 0);
		// long full-scale vector, back to back, so the sum runs well past 32 bits
		for (int i = 0; i < LONG_WORDS; i++)
			queue_word(16'h7fff, 16'h8000, (i == LONG_WORDS - 1), 0);
		// the sum must start from zero again afterwards
		queue_word(16'h0001, 16'h0000, 1'b1, 0);

		// random vectors, mostly short with the odd long one
		n_words = 0;
		while (n_words < RAND_WORDS) begin
			if ($urandom_range(0, 7) == 0)
				vec_len = $urandom_range(13, 64);
			else
				vec_len = $urandom_range(1, 12);
			quiet = ($urandom_range(0, 5) == 0);
			for (int i = 0; i < vec_len; i++)
				queue_word(pick_elem(), pick_elem(), (i == vec_len - 1),
					quiet ? 0 : $urandom_range(0, 11));
			n_words += vec_len;
		end

		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		while (elem_q.size() != 0 || have_cur || in_valid || distance_q.size() != 0)
			@(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);

		if (mismatches == 0 && distance_q.size() == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule
